// ===== design/mfig_pkg.sv =====
// Shared types, constants and register codes for the median filter instability guard.
package mfig_pkg;

	localparam int DEFAULT_WINDOW      = 5;
	localparam int DEFAULT_SAMPLE_BITS = 16;

	localparam int PORT_BITS  = 16;
	localparam int LIMIT_BITS = 4;
	localparam int INDEX_BITS = 2;

	localparam logic [PORT_BITS-1:0]  RESET_RANGE_THRESHOLD = 16'd500;
	localparam logic [LIMIT_BITS-1:0] RESET_BAD_LIMIT       = 4'd3;
	localparam logic [LIMIT_BITS-1:0] RESET_GOOD_LIMIT      = 4'd8;

	localparam logic [INDEX_BITS-1:0] REG_RANGE_THRESHOLD = 2'd0;
	localparam logic [INDEX_BITS-1:0] REG_BAD_LIMIT       = 2'd1;
	localparam logic [INDEX_BITS-1:0] REG_GOOD_LIMIT      = 2'd2;

	typedef struct packed {
		logic [PORT_BITS-1:0]  range_threshold;
		logic [LIMIT_BITS-1:0] bad_limit;
		logic [LIMIT_BITS-1:0] good_limit;
	} cfg_t;

endpackage

// ===== design/mfig_window.sv =====
// Ring window store with write position, fill count and the stage 1 valid flag.
module mfig_window #(
	parameter int WINDOW      = mfig_pkg::DEFAULT_WINDOW,
	parameter int SAMPLE_BITS = mfig_pkg::DEFAULT_SAMPLE_BITS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  accept,
	input  logic                                  take,
	input  logic [mfig_pkg::PORT_BITS-1:0]        pressure_sample,
	output logic                                  valid_s1,
	output logic [SAMPLE_BITS-1:0]                window_q [WINDOW],
	output logic [$clog2(WINDOW+1)-1:0]           fill_q
);
	import mfig_pkg::*;

	localparam int PW = $clog2(WINDOW);
	localparam int FW = $clog2(WINDOW + 1);

	logic [PW-1:0] wpos_q;
	logic [31:0]   sample_ext;

	// Bits above SAMPLE_BITS are dropped; narrow ports zero-extend.
	assign sample_ext = 32'(pressure_sample);

	always_ff @(posedge clk) begin
		if (accept) begin
			window_q[wpos_q] <= sample_ext[SAMPLE_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpos_q   <= '0;
			fill_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				wpos_q <= (wpos_q == PW'(WINDOW - 1)) ? '0 : wpos_q + PW'(1);
				if (fill_q != FW'(WINDOW)) begin
					fill_q <= fill_q + FW'(1);
				end
				valid_s1 <= 1'b1;
			end else if (take) begin
				valid_s1 <= 1'b0;
			end
		end
	end

endmodule

// ===== design/mfig_select.sv =====
// Rank network over the window: median of filled entries and full-window range.
module mfig_select #(
	parameter int WINDOW      = mfig_pkg::DEFAULT_WINDOW,
	parameter int SAMPLE_BITS = mfig_pkg::DEFAULT_SAMPLE_BITS
) (
	input  logic [SAMPLE_BITS-1:0]      window_q [WINDOW],
	input  logic [$clog2(WINDOW+1)-1:0] fill,
	output logic [SAMPLE_BITS-1:0]      median,
	output logic [SAMPLE_BITS-1:0]      range
);
	import mfig_pkg::*;

	localparam int RW = $clog2(WINDOW);
	localparam int FW = $clog2(WINDOW + 1);

	logic [RW-1:0]          rank [WINDOW];
	logic [RW-1:0]          hi_k;
	logic [RW-1:0]          lo_k;
	logic [SAMPLE_BITS-1:0] lo_v;
	logic [SAMPLE_BITS-1:0] hi_v;
	logic [SAMPLE_BITS-1:0] min_v;
	logic [SAMPLE_BITS-1:0] max_v;
	logic [SAMPLE_BITS:0]   mid_sum;

	// Rank each filled entry; equal values are ordered by position.
	always_comb begin
		for (int i = 0; i < WINDOW; i++) begin
			rank[i] = '0;
			for (int j = 0; j < WINDOW; j++) begin
				if (j != i && FW'(j) < fill &&
				    (window_q[j] < window_q[i] || (window_q[j] == window_q[i] && j < i))) begin
					rank[i] = rank[i] + RW'(1);
				end
			end
		end
	end

	assign hi_k = RW'(fill >> 1);
	assign lo_k = fill[0] ? hi_k : hi_k - RW'(1);

	always_comb begin
		lo_v  = '0;
		hi_v  = '0;
		min_v = '0;
		max_v = '0;
		for (int i = 0; i < WINDOW; i++) begin
			if (FW'(i) < fill) begin
				if (rank[i] == lo_k)             lo_v  = lo_v  | window_q[i];
				if (rank[i] == hi_k)             hi_v  = hi_v  | window_q[i];
				if (rank[i] == '0)               min_v = min_v | window_q[i];
				if (rank[i] == RW'(WINDOW - 1))  max_v = max_v | window_q[i];
			end
		end
	end

	assign mid_sum = {1'b0, lo_v} + {1'b0, hi_v};
	assign median  = mid_sum[SAMPLE_BITS:1];
	assign range   = max_v - min_v;

endmodule

// ===== design/mfig_guard.sv =====
// Wide/narrow run counters, instability flag and the result register.
module mfig_guard #(
	parameter int SAMPLE_BITS = mfig_pkg::DEFAULT_SAMPLE_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           take,
	input  logic                           pop,
	input  logic                           full,
	input  mfig_pkg::cfg_t                 cfg,
	input  logic [SAMPLE_BITS-1:0]         median,
	input  logic [SAMPLE_BITS-1:0]         range,
	output logic                           out_valid_q,
	output logic [mfig_pkg::PORT_BITS-1:0] filtered_pressure_q,
	output logic                           suppressed_q,
	output logic                           unstable_q
);
	import mfig_pkg::*;

	localparam int CW = (SAMPLE_BITS > PORT_BITS) ? SAMPLE_BITS : PORT_BITS;

	logic [LIMIT_BITS-1:0] wide_q, narrow_q, wide_n, narrow_n;
	logic [LIMIT_BITS:0]   wide_inc, narrow_inc;
	logic                  flag_q, flag_n;
	logic                  is_wide;
	logic                  suppress_n;
	logic [31:0]           median_ext;

	assign is_wide    = CW'(range) > CW'(cfg.range_threshold);
	assign wide_inc   = {1'b0, wide_q} + (LIMIT_BITS+1)'(1);
	assign narrow_inc = {1'b0, narrow_q} + (LIMIT_BITS+1)'(1);
	assign median_ext = 32'(median);

	always_comb begin
		wide_n   = wide_q;
		narrow_n = narrow_q;
		flag_n   = flag_q;
		if (full) begin
			if (is_wide) begin
				narrow_n = '0;
				if (wide_inc >= {1'b0, cfg.bad_limit}) begin
					wide_n = cfg.bad_limit;
					flag_n = 1'b1;
				end else begin
					wide_n = wide_inc[LIMIT_BITS-1:0];
				end
			end else begin
				wide_n = '0;
				if (narrow_inc >= {1'b0, cfg.good_limit}) begin
					narrow_n = cfg.good_limit;
					flag_n   = 1'b0;
				end else begin
					narrow_n = narrow_inc[LIMIT_BITS-1:0];
				end
			end
		end
		suppress_n = (wide_n != '0) || flag_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wide_q      <= '0;
			narrow_q    <= '0;
			flag_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				wide_q      <= wide_n;
				narrow_q    <= narrow_n;
				flag_q      <= flag_n;
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			filtered_pressure_q <= suppress_n ? '0 : median_ext[PORT_BITS-1:0];
			suppressed_q        <= suppress_n;
			unstable_q          <= flag_n;
		end
	end

endmodule

// ===== design/median_filter_instability_guard.sv =====
// Top level of the median filter with sensor instability guard.
//
// Each accepted word carries one unsigned pressure sample in millibar. It is written
// into a ring window of WINDOW entries at the accepting edge, and once the result
// register is free the result word is registered: the median of the filled entries
// (floor average of the two middle values while the window holds an even count),
// the suppressed flag and the unstable flag. Once the window is full, a window range
// above range_threshold counts toward bad_limit and sets the unstable flag; narrow
// windows count toward good_limit and clear it. The median reads as zero while a
// wide run is open or the flag is set. Rate: one word per cycle sustained while
// out_stall stays low; the rank-compare network over the window registers feeds the
// counter update and the result register. in_stall rises only while a result waits
// on out_stall and another word already sits in the window stage.
// Configuration writes are always ready and take effect on the next word; write them
// only while no word is in flight. Window entries have no reset; nothing reads an
// entry before it is written.
module median_filter_instability_guard #(
	parameter int WINDOW      = mfig_pkg::DEFAULT_WINDOW,
	parameter int SAMPLE_BITS = mfig_pkg::DEFAULT_SAMPLE_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [mfig_pkg::PORT_BITS-1:0]  pressure_sample,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [mfig_pkg::PORT_BITS-1:0]  filtered_pressure,
	output logic                            suppressed,
	output logic                            unstable,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [mfig_pkg::INDEX_BITS-1:0] cfg_index,
	input  logic [mfig_pkg::PORT_BITS-1:0]  cfg_data
);
	import mfig_pkg::*;

	localparam int FW = $clog2(WINDOW + 1);

	cfg_t                   cfg_q;
	logic                   valid_s1;
	logic                   out_free;
	logic                   take;
	logic                   accept;
	logic                   pop;
	logic [SAMPLE_BITS-1:0] window_q [WINDOW];
	logic [FW-1:0]          fill_q;
	logic [SAMPLE_BITS-1:0] median;
	logic [SAMPLE_BITS-1:0] range;

	// Advance the window stage whenever the result register is empty or draining.
	assign out_free  = !out_valid || !out_stall;
	assign take      = valid_s1 && out_free;
	// Hold off new words only when the window stage cannot move on.
	assign in_stall  = valid_s1 && !out_free;
	assign accept    = in_valid && !in_stall;
	assign pop       = out_valid && !out_stall;
	assign cfg_ready = 1'b1;

	// Register file; unknown indexes drop the write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.range_threshold <= RESET_RANGE_THRESHOLD;
			cfg_q.bad_limit       <= RESET_BAD_LIMIT;
			cfg_q.good_limit      <= RESET_GOOD_LIMIT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_RANGE_THRESHOLD: cfg_q.range_threshold <= cfg_data;
				REG_BAD_LIMIT:       cfg_q.bad_limit       <= cfg_data[LIMIT_BITS-1:0];
				REG_GOOD_LIMIT:      cfg_q.good_limit      <= cfg_data[LIMIT_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	mfig_window #(
		.WINDOW      (WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_window (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.take            (take),
		.pressure_sample (pressure_sample),
		.valid_s1        (valid_s1),
		.window_q        (window_q),
		.fill_q          (fill_q)
	);

	mfig_select #(
		.WINDOW      (WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_select (
		.window_q (window_q),
		.fill     (fill_q),
		.median   (median),
		.range    (range)
	);

	mfig_guard #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_guard (
		.clk                 (clk),
		.arst_n              (arst_n),
		.take                (take),
		.pop                 (pop),
		.full                (fill_q == FW'(WINDOW)),
		.cfg                 (cfg_q),
		.median              (median),
		.range               (range),
		.out_valid_q         (out_valid),
		.filtered_pressure_q (filtered_pressure),
		.suppressed_q        (suppressed),
		.unstable_q          (unstable)
	);

endmodule

// ===== design/mfig_checker.sv =====
// Port-level checker for the median filter instability guard, bound to the top level.
module mfig_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_stall,
	input logic [mfig_pkg::PORT_BITS-1:0]  pressure_sample,
	input logic                            out_valid,
	input logic                            out_stall,
	input logic [mfig_pkg::PORT_BITS-1:0]  filtered_pressure,
	input logic                            suppressed,
	input logic                            unstable
);

	// A suppressed word carries a zero median.
	a_suppressed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && suppressed |-> filtered_pressure == '0)
		else $error("suppressed word with nonzero median");

	// An unstable sensor always suppresses the output.
	a_unstable_suppresses: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && unstable |-> suppressed)
		else $error("unstable flag without suppression");

	// Input backpressure only comes from a stalled, full result register.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while result side is free");

	// A stalled result word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(filtered_pressure) &&
			$stable(suppressed) && $stable(unstable))
		else $error("stalled result word changed");

	// A stalled input word holds.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(pressure_sample))
		else $error("stalled input word changed");

endmodule

bind median_filter_instability_guard mfig_checker u_mfig_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.in_valid          (in_valid),
	.in_stall          (in_stall),
	.pressure_sample   (pressure_sample),
	.out_valid         (out_valid),
	.out_stall         (out_stall),
	.filtered_pressure (filtered_pressure),
	.suppressed        (suppressed),
	.unstable          (unstable)
);

// ===== tb/tb_median_filter_instability_guard.sv =====
// Self-checking testbench for the median filter with sensor instability guard.
`timescale 1ns / 1ps

module tb_median_filter_instability_guard;
	import mfig_pkg::*;

	localparam int CLK_HALF     = 6;
	localparam int WINDOW_DEPTH = DEFAULT_WINDOW;
	localparam int MAX_GAP      = 40;
	localparam int DRAIN_LIMIT  = 5000;
	localparam int HOLD_CYCLES  = 60;
	localparam int RUN_CYCLES   = 300000;

	// Index that decodes to no register; writes to it must be dropped.
	localparam logic [INDEX_BITS-1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic [PORT_BITS-1:0] filtered_pressure;
		logic                 suppressed;
		logic                 unstable;
	} median_word_t;

	// Block ports; every input holds a known value from time zero.
	logic                  clk             = 1'b0;
	logic                  arst_n          = 1'b0;
	logic                  in_valid        = 1'b0;
	logic                  in_stall;
	logic [PORT_BITS-1:0]  pressure_sample = '0;
	logic                  out_valid;
	logic                  out_stall       = 1'b0;
	logic [PORT_BITS-1:0]  filtered_pressure;
	logic                  suppressed;
	logic                  unstable;
	logic                  cfg_valid       = 1'b0;
	logic                  cfg_ready;
	logic [INDEX_BITS-1:0] cfg_index       = '0;
	logic [PORT_BITS-1:0]  cfg_data        = '0;

	// Mirror of the filter state and its registers, advanced once per accepted word.
	logic [PORT_BITS-1:0]  win_q [WINDOW_DEPTH];
	int                    wr_pos   = 0;
	int                    fill_n   = 0;
	int                    wide_n   = 0;
	int                    narrow_n = 0;
	logic                  flag_q   = 1'b0;
	logic [PORT_BITS-1:0]  thr_q    = RESET_RANGE_THRESHOLD;
	logic [LIMIT_BITS-1:0] bad_q    = RESET_BAD_LIMIT;
	logic [LIMIT_BITS-1:0] good_q   = RESET_GOOD_LIMIT;

	// Result words predicted for accepted samples, oldest first.
	median_word_t pending_medians [$];

	// Traffic shaping knobs, set by the test tasks.
	int tx_idle_pct  = 0;
	int rx_stall_pct = 0;
	int hold_req     = 0;

	// Sample generator state: a base level that steps at random, with bursts of spikes.
	int base_mb    = 1013;
	int storm_left = 0;

	// Run statistics.
	int err_count       = 0;
	int samples_sent    = 0;
	int results_checked = 0;
	int reg_writes      = 0;
	int in_stall_cycles = 0;

	median_filter_instability_guard u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.pressure_sample   (pressure_sample),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.filtered_pressure (filtered_pressure),
		.suppressed        (suppressed),
		.unstable          (unstable),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// Push one sample through the mirrored window and return the word the block
	// should answer with. Only entries from position zero up to the fill count are
	// read, and those are always written first.
	function automatic median_word_t median_after(input logic [PORT_BITS-1:0] sample);
		logic [PORT_BITS-1:0] sorted_win [WINDOW_DEPTH];
		logic [PORT_BITS-1:0] key;
		logic [PORT_BITS:0]   pair_sum;
		median_word_t         res;
		int                   k;
		int                   mid;
		win_q[wr_pos] = sample;
		wr_pos = (wr_pos + 1) % WINDOW_DEPTH;
		if (fill_n < WINDOW_DEPTH)
			fill_n++;
		for (int i = 0; i < fill_n; i++)
			sorted_win[i] = win_q[i];
		// Insertion sort, ascending.
		for (int i = 1; i < fill_n; i++) begin
			key = sorted_win[i];
			k = i;
			while (k > 0 && sorted_win[k-1] > key) begin
				sorted_win[k] = sorted_win[k-1];
				k--;
			end
			sorted_win[k] = key;
		end
		// Run counters move only once the window is full. A limit of zero, or a
		// limit lowered below the running count, is reached on the next update.
		if (fill_n == WINDOW_DEPTH) begin
			if (sorted_win[fill_n-1] - sorted_win[0] > thr_q) begin
				narrow_n = 0;
				wide_n++;
				if (wide_n >= int'(bad_q)) begin
					wide_n = int'(bad_q);
					flag_q = 1'b1;
				end
			end else begin
				wide_n = 0;
				narrow_n++;
				if (narrow_n >= int'(good_q)) begin
					narrow_n = int'(good_q);
					flag_q = 1'b0;
				end
			end
		end
		res.suppressed        = (wide_n != 0) || flag_q;
		res.unstable          = flag_q;
		res.filtered_pressure = '0;
		if (!res.suppressed) begin
			mid = fill_n / 2;
			if (fill_n % 2)
				res.filtered_pressure = sorted_win[mid];
			else begin
				// Floor average of the two middle values; keep the carry bit.
				pair_sum = {1'b0, sorted_win[mid-1]} + {1'b0, sorted_win[mid]};
				res.filtered_pressure = pair_sum[PORT_BITS:1];
			end
		end
		return res;
	endfunction

	// Draw a pressure sample. Most draws sit on the base level within the range
	// threshold, so windows mostly stay narrow and the good run can complete; the
	// rest are threshold edges, level steps, extremes and bursts of wide spikes.
	function automatic logic [PORT_BITS-1:0] next_sample();
		int v;
		int r;
		r = $urandom_range(0, 99);
		if (storm_left > 0) begin
			storm_left--;
			v = $urandom_range(0, 65535);
		end else if (r < 3) begin
			storm_left = $urandom_range(1, 8);
			v = $urandom_range(0, 65535);
		end else if (r < 8)
			v = $urandom_range(0, 65535);
		else if (r < 10)
			v = 0;
		else if (r < 12)
			v = 65535;
		else if (r < 14) begin
			base_mb = $urandom_range(0, 65535);
			v = base_mb;
		end else if (r < 20)
			v = base_mb;
		else if (r < 24)
			v = base_mb + int'(thr_q);
		else if (r < 27)
			v = base_mb + int'(thr_q) + 1;
		else
			v = base_mb + int'($urandom_range(0, int'(thr_q)));
		if (v > 65535)
			v = 65535;
		return v[PORT_BITS-1:0];
	endfunction

	// Offer one sample word and hold it until accepted, then predict its result.
	// Afterwards idle the sender for a random number of cycles; with no idling,
	// valid stays high so the next word follows without a gap.
	task automatic send_sample(input logic [PORT_BITS-1:0] sample);
		int gap;
		pressure_sample <= sample;
		in_valid        <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_medians.push_back(median_after(sample));
		samples_sent++;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(0, 99) < tx_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop valid and wait until every predicted word has come back, then let the
	// pipeline settle before anything touches the registers.
	task automatic drain_results();
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		while (pending_medians.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (3) @(posedge clk);
	endtask

	// Write one register word; only called while the block is idle. Leave a quiet
	// gap after each write so valid is never lowered and raised at once.
	task automatic write_reg(input logic [INDEX_BITS-1:0] idx,
	                         input logic [PORT_BITS-1:0]  data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_RANGE_THRESHOLD: thr_q  = data;
			REG_BAD_LIMIT:       bad_q  = data[LIMIT_BITS-1:0];
			REG_GOOD_LIMIT:      good_q = data[LIMIT_BITS-1:0];
			default: ;
		endcase
		reg_writes++;
		@(posedge clk);
	endtask

	// Receiver: stall at random, or hold off for a counted stretch on request.
	always @(posedge clk) begin
		static int hold_left = 0;
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req  = 0;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else
			out_stall <= (arst_n && $urandom_range(0, 99) < rx_stall_pct) ? 1'b1 : 1'b0;
	end

	always @(posedge clk)
		if (in_valid && in_stall)
			in_stall_cycles++;

	// Compare each accepted result word, field by field, with the oldest prediction.
	always @(posedge clk) begin
		median_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_medians.size() == 0) begin
				$error("unexpected result word: filtered_pressure %0d", filtered_pressure);
				err_count++;
			end else begin
				want = pending_medians.pop_front();
				results_checked++;
				if (filtered_pressure !== want.filtered_pressure) begin
					$error("filtered_pressure: expected %0d, actual %0d",
					       want.filtered_pressure, filtered_pressure);
					err_count++;
				end
				if (suppressed !== want.suppressed) begin
					$error("suppressed: expected %0b, actual %0b", want.suppressed, suppressed);
					err_count++;
				end
				if (unstable !== want.unstable) begin
					$error("unstable: expected %0b, actual %0b", want.unstable, unstable);
					err_count++;
				end
			end
		end
	end

	// Window filling from reset: one, two (average of the extremes' neighbors with
	// carry), three and four samples, then the first full window, which is wide and
	// so suppressed although the flag is still clear.
	task automatic test_window_fill();
		send_sample(16'd65535);
		send_sample(16'd65534);
		send_sample(16'd0);
		send_sample(16'd1);
		send_sample(16'd40000);
		drain_results();
	endtask

	// Default limits: keep the window wide until the flag sets, then feed a steady
	// level long enough for the good run to clear it again.
	task automatic test_instability_run();
		send_sample(16'd0);
		send_sample(16'd65535);
		send_sample(16'd0);
		repeat (12) send_sample(16'd1000);
		drain_results();
	endtask

	// Register extremes: zero threshold and zero limits (upper data bits must be
	// masked off), a write to the unused index, the widest threshold with the
	// largest limits, and a bad limit lowered below a running wide count.
	task automatic test_register_extremes();
		write_reg(REG_RANGE_THRESHOLD, 16'd0);
		write_reg(REG_BAD_LIMIT, 16'hFFF0);
		write_reg(REG_GOOD_LIMIT, 16'h0010);
		write_reg(REG_UNUSED, 16'hFFFF);
		send_sample(16'd1000);
		send_sample(16'd1001);
		send_sample(16'd1000);
		drain_results();
		write_reg(REG_RANGE_THRESHOLD, 16'hFFFF);
		write_reg(REG_BAD_LIMIT, 16'hFFFF);
		write_reg(REG_GOOD_LIMIT, 16'h000F);
		send_sample(16'd0);
		send_sample(16'd65535);
		drain_results();
		write_reg(REG_RANGE_THRESHOLD, 16'd0);
		send_sample(16'd7);
		send_sample(16'd65000);
		drain_results();
		write_reg(REG_BAD_LIMIT, 16'h0001);
		send_sample(16'd12345);
		drain_results();
	endtask

	// Random traffic under one idling pattern, in two halves with a fresh random
	// register setting before each half.
	task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int n_items);
		logic [PORT_BITS-1:0] data;
		tx_idle_pct  = tx_pct;
		rx_stall_pct = rx_pct;
		for (int half = 0; half < 2; half++) begin
			case ($urandom_range(0, 9))
				0:       data = 16'd0;
				1:       data = 16'hFFFF;
				2, 3:    data = 16'($urandom_range(0, 65535));
				default: data = 16'($urandom_range(1, 3000));
			endcase
			write_reg(REG_RANGE_THRESHOLD, data);
			data = 16'($urandom_range(0, 65535));
			write_reg(REG_BAD_LIMIT, data);
			data = 16'($urandom_range(0, 65535));
			write_reg(REG_GOOD_LIMIT, data);
			if ($urandom_range(0, 9) < 3) begin
				data = 16'($urandom_range(0, 65535));
				write_reg(REG_UNUSED, data);
			end
			repeat (n_items / 2) send_sample(next_sample());
			drain_results();
		end
	endtask

	// Hold the receiver off for a long counted stretch while the sender offers
	// words back to back, so the pipeline fills and the input stalls.
	task automatic test_backpressure();
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		hold_req     = HOLD_CYCLES;
		repeat (24) send_sample(next_sample());
		drain_results();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_window_fill();
		test_instability_run();
		test_register_extremes();
		test_random_traffic(0, 0, 200);
		test_random_traffic(52, 0, 200);
		test_random_traffic(0, 52, 200);
		test_random_traffic(11, 11, 200);
		test_backpressure();

		if (pending_medians.size() != 0) begin
			$error("%0d result words never arrived", pending_medians.size());
			err_count++;
		end
		$display("Covered window fill, flag set and clear, register extremes and random traffic");
		$display("%0d samples, %0d results checked, %0d register writes, %0d input stall cycles",
		         samples_sent, results_checked, reg_writes, in_stall_cycles);
		if (err_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Hard stop well past the slowest correct run.
	initial begin
		#(2 * CLK_HALF * RUN_CYCLES);
		$display("Some tests failed");
		$finish;
	end

endmodule
